// ===== sv/kwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way merge block
// Holds the heap geometry, the heap entry format and the command and response
// structures between the merge controller and the heap engine.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int MAX_RUNS = 256;
  localparam int IDX_W    = $clog2(MAX_RUNS);
  localparam int SIZE_W   = IDX_W + 1;
  localparam int CH_W     = IDX_W + 2;
  localparam int KEY_W    = 32;
  localparam int RUN_W    = 8;
  localparam int CFG_W    = 9;
  localparam int LIM_W    = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] run;
  } kwm_entry_t;

  typedef struct packed {
    logic       clear;
    logic       ins;
    logic       pop;
    kwm_entry_t ent;
  } kwm_cmd_t;

  typedef struct packed {
    logic       done;
    logic       empty;
    kwm_entry_t top;
  } kwm_rsp_t;

endpackage

// ===== sv/kwm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_if: channel interfaces of the k-way merge block
// The input channel carries run heads; the output channel carries merged
// values with their run numbers and the end-of-merge flag.
// ----------------------------------------------------------------------------
interface kwm_in_if import kwm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] head_value;
  logic             has_value;

  modport source (output valid, output head_value, output has_value, input ready);
  modport sink (input valid, input head_value, input has_value, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] out_value;
  logic [RUN_W-1:0] out_run;
  logic             done_res;

  modport source (output valid, output out_value, output out_run, output done_res,
                  input ready);
  modport sink (input valid, input out_value, input out_run, input done_res,
                output ready);
endinterface

// ===== sv/kwm_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_cmp: heap entry comparator
// Orders entries by value and then by run number; lt is high when a comes
// strictly before b.
// ----------------------------------------------------------------------------
module kwm_cmp import kwm_pkg::*; (
  input  kwm_entry_t a,
  input  kwm_entry_t b,
  output logic       lt
);

  always_comb begin
    if (a.key != b.key) begin
      lt = a.key < b.key;
    end else begin
      lt = a.run < b.run;
    end
  end

endmodule

// ===== sv/kwm_heap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_heap: min-heap engine
// Keeps the heap in a RAM with one write and two registered read ports and
// runs insert and pop operations as sift-up and sift-down loops over the
// shared comparator, one tree level per E_UP step up or per E_C1/E_C2 pair down.
// ----------------------------------------------------------------------------
module kwm_heap import kwm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  kwm_cmd_t cmd,
  output kwm_rsp_t rsp
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_UP,
    E_WR,
    E_POP_RD,
    E_POP_TK,
    E_C1,
    E_C2,
    E_FIN
  } eng_state_t;

  eng_state_t        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              pend_pop_r, pend_pop_nxt;
  logic              empty_r, empty_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  cidx_r, cidx_nxt;
  kwm_entry_t        item_r, item_nxt;
  kwm_entry_t        child_r, child_nxt;
  kwm_entry_t        top_r, top_nxt;

  kwm_entry_t        heap_mem [MAX_RUNS];
  kwm_entry_t        rd_a_r, rd_b_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  kwm_entry_t        mem_wdata;
  logic [IDX_W-1:0]  mem_ra, mem_rb;

  kwm_entry_t        cmp_a, cmp_b;
  logic              cmp_lt;

  logic [SIZE_W-1:0] size_eff;
  logic [IDX_W-1:0]  up_p, up_p2, new_p;
  logic [CH_W-1:0]   l_idx, r_idx, cl_idx, cr_idx, size_ext;

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] dec;
    dec = idx - IDX_W'(1);
    return dec >> 1;
  endfunction

  kwm_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  always_comb begin
    case (state_r)
      E_C1: begin
        cmp_a = rd_b_r;
        cmp_b = rd_a_r;
      end
      E_C2: begin
        cmp_a = child_r;
        cmp_b = item_r;
      end
      default: begin
        cmp_a = item_r;
        cmp_b = rd_a_r;
      end
    endcase
  end

  assign size_eff = cmd.clear ? '0 : size_r;
  assign up_p     = parent_of(i_r);
  assign up_p2    = parent_of(up_p);
  assign new_p    = parent_of(size_eff[IDX_W-1:0]);
  assign l_idx    = {1'b0, i_r, 1'b1};
  assign r_idx    = l_idx + CH_W'(1);
  assign cl_idx   = {1'b0, cidx_r, 1'b1};
  assign cr_idx   = cl_idx + CH_W'(1);
  assign size_ext = CH_W'(size_r);

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    pend_pop_nxt = pend_pop_r;
    empty_nxt    = empty_r;
    i_nxt        = i_r;
    cidx_nxt     = cidx_r;
    item_nxt     = item_r;
    child_nxt    = child_r;
    top_nxt      = top_r;
    mem_we       = 1'b0;
    mem_waddr    = i_r;
    mem_wdata    = item_r;
    mem_ra       = '0;
    mem_rb       = '0;
    case (state_r)
      E_IDLE: begin
        if (start) begin
          empty_nxt    = 1'b0;
          pend_pop_nxt = cmd.pop;
          if (cmd.ins && (size_eff < SIZE_W'(MAX_RUNS))) begin
            item_nxt = cmd.ent;
            i_nxt    = size_eff[IDX_W-1:0];
            size_nxt = size_eff + SIZE_W'(1);
            if (size_eff == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = cmd.ent;
              state_nxt = cmd.pop ? E_POP_RD : E_FIN;
            end else begin
              mem_ra    = new_p;
              state_nxt = E_UP;
            end
          end else begin
            size_nxt  = size_eff;
            state_nxt = cmd.pop ? E_POP_RD : E_FIN;
          end
        end
      end
      E_UP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = rd_a_r;
          i_nxt     = up_p;
          if (up_p == '0) begin
            state_nxt = E_WR;
          end else begin
            mem_ra = up_p2;
          end
        end else begin
          state_nxt = pend_pop_r ? E_POP_RD : E_FIN;
        end
      end
      E_WR: begin
        mem_we    = 1'b1;
        state_nxt = pend_pop_r ? E_POP_RD : E_FIN;
      end
      E_POP_RD: begin
        pend_pop_nxt = 1'b0;
        if (size_r == '0) begin
          empty_nxt = 1'b1;
          state_nxt = E_FIN;
        end else begin
          mem_ra    = '0;
          mem_rb    = IDX_W'(size_r - SIZE_W'(1));
          size_nxt  = size_r - SIZE_W'(1);
          state_nxt = E_POP_TK;
        end
      end
      E_POP_TK: begin
        top_nxt  = rd_a_r;
        item_nxt = rd_b_r;
        i_nxt    = '0;
        if (size_r == '0) begin
          state_nxt = E_FIN;
        end else if (size_r == SIZE_W'(1)) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = rd_b_r;
          state_nxt = E_FIN;
        end else begin
          mem_ra    = IDX_W'(1);
          mem_rb    = IDX_W'(2);
          state_nxt = E_C1;
        end
      end
      E_C1: begin
        if ((r_idx < size_ext) && cmp_lt) begin
          child_nxt = rd_b_r;
          cidx_nxt  = r_idx[IDX_W-1:0];
        end else begin
          child_nxt = rd_a_r;
          cidx_nxt  = l_idx[IDX_W-1:0];
        end
        state_nxt = E_C2;
      end
      E_C2: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = child_r;
          i_nxt     = cidx_r;
          if (cl_idx < size_ext) begin
            mem_ra    = cl_idx[IDX_W-1:0];
            mem_rb    = cr_idx[IDX_W-1:0];
            state_nxt = E_C1;
          end else begin
            state_nxt = E_WR;
          end
        end else begin
          state_nxt = E_FIN;
        end
      end
      E_FIN: begin
        state_nxt = E_IDLE;
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= heap_mem[mem_ra];
    rd_b_r <= heap_mem[mem_rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= E_IDLE;
      size_r     <= '0;
      pend_pop_r <= 1'b0;
      empty_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      size_r     <= size_nxt;
      pend_pop_r <= pend_pop_nxt;
      empty_r    <= empty_nxt;
    end
    i_r     <= i_nxt;
    cidx_r  <= cidx_nxt;
    item_r  <= item_nxt;
    child_r <= child_nxt;
    top_r   <= top_nxt;
  end

  assign rsp.done  = (state_r == E_FIN);
  assign rsp.empty = empty_r;
  assign rsp.top   = top_r;

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SIZE_W'(MAX_RUNS))
    else $error("heap size above capacity");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == E_IDLE)
    else $error("heap command issued while an operation is running");

  a_sift_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_C2 |-> SIZE_W'(i_r) < size_r)
    else $error("sift-down position outside the heap");

endmodule

// ===== sv/k_way_merge_min_heap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_merge_min_heap: k-way merge of sorted runs through a min-heap
// Usage: write the run count on cfg_wdata with cfg_we while the block is idle.
// A pass starts with one in_ch transaction per run, in run order, carrying the
// run's first value or has_value low for an empty run. After the last fill
// transaction and after every later one, out_ch delivers the smallest head and
// its run; the next in_ch transaction must refill that run, with its next
// value or has_value low once the run is exhausted. When no heads remain,
// out_ch delivers done_res high with zero value and run, and the next
// transaction starts a new fill phase.
// Flow: one transaction is worked at a time. A fill transaction that needs
// no heap work leaves the heap engine idle. An insert sifts up one tree
// level at a time and a pop sifts down one level at a time; a transaction
// that does both runs the insert first. The single heap RAM write port and
// the one shared comparator make each level a separate heap engine step.
// Reset clears the pass state and sets the run count to 256. A stalled out_ch
// keeps its result in the output register; the block still takes the next
// in_ch transaction and holds its result until the register is free.
// ----------------------------------------------------------------------------
module k_way_merge_min_heap import kwm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  kwm_in_if.sink           in_ch,
  kwm_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_HOLD
  } top_state_t;

  top_state_t        state_r, state_nxt;
  logic [CFG_W-1:0]  runs_in_use_r, runs_in_use_nxt;
  logic [SIZE_W-1:0] fill_index_r, fill_index_nxt;
  logic [IDX_W-1:0]  refill_run_r, refill_run_nxt;
  logic              merging_r, merging_nxt;
  logic              pop_req_r, pop_req_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]  out_value_r, out_value_nxt;
  logic [RUN_W-1:0]  out_run_r, out_run_nxt;
  logic              out_done_r, out_done_nxt;
  logic [KEY_W-1:0]  res_value_r, res_value_nxt;
  logic [RUN_W-1:0]  res_run_r, res_run_nxt;
  logic              res_done_r, res_done_nxt;

  logic [LIM_W-1:0]  cfg_ext, lim_ext;
  logic [SIZE_W-1:0] limit, fill_inc;
  logic              fill_last, accept, out_free, start;
  logic [KEY_W-1:0]  pop_value;
  logic [RUN_W-1:0]  pop_run;
  kwm_cmd_t          cmd;
  kwm_rsp_t          rsp;

  kwm_heap u_heap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  assign cfg_ext = LIM_W'(runs_in_use_r);
  assign lim_ext = (cfg_ext == '0) ? LIM_W'(1) :
                   (cfg_ext > LIM_W'(MAX_RUNS)) ? LIM_W'(MAX_RUNS) : cfg_ext;
  assign limit     = SIZE_W'(lim_ext);
  assign fill_inc  = fill_index_r + SIZE_W'(1);
  assign fill_last = fill_inc >= limit;

  assign in_ch.ready = (state_r == T_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign pop_value   = rsp.empty ? '0 : rsp.top.key;
  assign pop_run     = rsp.empty ? '0 : RUN_W'(rsp.top.run);

  always_comb begin
    state_nxt       = state_r;
    runs_in_use_nxt = cfg_we ? cfg_wdata : runs_in_use_r;
    fill_index_nxt  = fill_index_r;
    refill_run_nxt  = refill_run_r;
    merging_nxt     = merging_r;
    pop_req_nxt     = pop_req_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_value_nxt   = out_value_r;
    out_run_nxt     = out_run_r;
    out_done_nxt    = out_done_r;
    res_value_nxt   = res_value_r;
    res_run_nxt     = res_run_r;
    res_done_nxt    = res_done_r;
    cmd             = '0;
    start           = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          cmd.ent.key = in_ch.head_value;
          cmd.ins     = in_ch.has_value;
          if (merging_r) begin
            cmd.ent.run = refill_run_r;
            cmd.pop     = 1'b1;
          end else begin
            cmd.clear      = (fill_index_r == '0);
            cmd.ent.run    = fill_index_r[IDX_W-1:0];
            cmd.pop        = fill_last;
            fill_index_nxt = fill_last ? '0 : fill_inc;
          end
          start       = cmd.clear || cmd.ins || cmd.pop;
          pop_req_nxt = cmd.pop;
          if (start) begin
            state_nxt = T_BUSY;
          end
        end
      end
      T_BUSY: begin
        if (rsp.done) begin
          if (pop_req_r) begin
            merging_nxt    = !rsp.empty;
            refill_run_nxt = rsp.empty ? '0 : rsp.top.run;
            res_value_nxt  = pop_value;
            res_run_nxt    = pop_run;
            res_done_nxt   = rsp.empty;
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_value_nxt = pop_value;
              out_run_nxt   = pop_run;
              out_done_nxt  = rsp.empty;
              state_nxt     = T_IDLE;
            end else begin
              state_nxt = T_HOLD;
            end
          end else begin
            state_nxt = T_IDLE;
          end
        end
      end
      T_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_run_nxt   = res_run_r;
          out_done_nxt  = res_done_r;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      runs_in_use_r <= CFG_RESET;
      fill_index_r  <= '0;
      refill_run_r  <= '0;
      merging_r     <= 1'b0;
      pop_req_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      runs_in_use_r <= runs_in_use_nxt;
      fill_index_r  <= fill_index_nxt;
      refill_run_r  <= refill_run_nxt;
      merging_r     <= merging_nxt;
      pop_req_r     <= pop_req_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
    out_run_r   <= out_run_nxt;
    out_done_r  <= out_done_nxt;
    res_value_r <= res_value_nxt;
    res_run_r   <= res_run_nxt;
    res_done_r  <= res_done_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.out_run   = out_run_r;
  assign out_ch.done_res  = out_done_r;

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_value_r == '0) && (out_run_r == '0))
    else $error("end-of-merge result carries a nonzero value or run");

  a_merge_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    merging_r |-> fill_index_r == '0)
    else $error("fill position left nonzero during the merge phase");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_index_r < SIZE_W'(MAX_RUNS))
    else $error("fill position beyond the last run");

endmodule

// ===== tb/k_way_merge_min_heap_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_merge_min_heap_tb: self-checking bench for the k-way merge block
// Feeds sorted runs through the fill and merge phases and refills the popped
// run as the block expects. A scoreboard class keeps its own min-heap of run
// heads and predicts every merged value, run number and done flag. Both
// channels see random idle bursts, one long output stall and quiet stretches.
// ----------------------------------------------------------------------------
module k_way_merge_min_heap_tb;
  import kwm_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int TAIL_CYCLES    = 50;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_ITEMS   = 90;

  localparam int SHAPE_TIES = 0;
  localparam int SHAPE_WIDE = 1;
  localparam int SHAPE_TOP  = 2;

  typedef struct {
    logic [KEY_W-1:0] value;
    logic [RUN_W-1:0] run;
    logic             done;
  } merge_result_t;

  class merge_scoreboard;
    logic [KEY_W-1:0] heap_key [MAX_RUNS];
    logic [IDX_W-1:0] heap_run [MAX_RUNS];
    int unsigned      heap_count;
    int unsigned      fill_pos;
    logic [IDX_W-1:0] next_refill;
    bit               merging;
    logic [CFG_W-1:0] run_count;
    merge_result_t    expected_q[$];
    int unsigned      errors;

    function new();
      heap_count  = 0;
      fill_pos    = 0;
      next_refill = '0;
      merging     = 1'b0;
      run_count   = CFG_RESET;
      errors      = 0;
    endfunction

    function void set_run_count(logic [CFG_W-1:0] count);
      run_count = count;
    endfunction

    function int unsigned run_limit();
      int unsigned n;
      n = run_count;
      if (n == 0) n = 1;
      if (n > MAX_RUNS) n = MAX_RUNS;
      return n;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit entry_before(int unsigned a, int unsigned b);
      if (heap_key[a] != heap_key[b]) return heap_key[a] < heap_key[b];
      return heap_run[a] < heap_run[b];
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      logic [KEY_W-1:0] k;
      logic [IDX_W-1:0] r;
      k = heap_key[a];
      r = heap_run[a];
      heap_key[a] = heap_key[b];
      heap_run[a] = heap_run[b];
      heap_key[b] = k;
      heap_run[b] = r;
    endfunction

    function void heap_push(logic [KEY_W-1:0] value, logic [IDX_W-1:0] run);
      int unsigned i;
      int unsigned p;
      if (heap_count >= MAX_RUNS) return;
      i = heap_count;
      heap_count++;
      heap_key[i] = value;
      heap_run[i] = run;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!entry_before(i, p)) break;
        swap_entries(i, p);
        i = p;
      end
    endfunction

    // Pops the smallest head, or flags the end of the pass once the heap is empty.
    function void report_top();
      merge_result_t res;
      int unsigned i;
      int unsigned l;
      int unsigned m;
      if (heap_count == 0) begin
        res.value   = '0;
        res.run     = '0;
        res.done    = 1'b1;
        merging     = 1'b0;
        fill_pos    = 0;
        next_refill = '0;
      end else begin
        res.value   = heap_key[0];
        res.run     = RUN_W'(heap_run[0]);
        res.done    = 1'b0;
        next_refill = heap_run[0];
        heap_count--;
        heap_key[0] = heap_key[heap_count];
        heap_run[0] = heap_run[heap_count];
        i = 0;
        forever begin
          l = 2 * i + 1;
          m = i;
          if (l < heap_count && entry_before(l, m)) m = l;
          if (l + 1 < heap_count && entry_before(l + 1, m)) m = l + 1;
          if (m == i) break;
          swap_entries(i, m);
          i = m;
        end
        merging = 1'b1;
      end
      expected_q = {expected_q, res};
    endfunction

    function void note_input(logic [KEY_W-1:0] value, logic has_value);
      if (merging) begin
        if (has_value) heap_push(value, next_refill);
        report_top();
      end else begin
        if (fill_pos == 0) heap_count = 0;
        if (has_value) heap_push(value, IDX_W'(fill_pos));
        fill_pos++;
        if (fill_pos >= run_limit()) begin
          fill_pos = 0;
          report_top();
        end
      end
    endfunction

    function void flag_mismatch(string field, logic [KEY_W-1:0] want,
                                logic [KEY_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [KEY_W-1:0] value, logic [RUN_W-1:0] run,
                               logic done);
      merge_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual value %0h run %0h done %0b",
                 $time, value, run, done);
        return;
      end
      want = expected_q.pop_front();
      if (want.value !== value) flag_mismatch("out_value", want.value, value);
      if (want.run !== run) flag_mismatch("out_run", KEY_W'(want.run), KEY_W'(run));
      if (want.done !== done) flag_mismatch("done_res", KEY_W'(want.done), KEY_W'(done));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  kwm_in_if  in_ch();
  kwm_out_if out_ch();

  k_way_merge_min_heap dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  merge_scoreboard  sb;
  logic [KEY_W-1:0] run_data [MAX_RUNS][$];
  bit               idle_on;
  bit               long_hold_req;
  bit               offering;
  int unsigned      items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic put_item(logic [KEY_W-1:0] value, logic has_value);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      if (offering) in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.head_value <= value;
    in_ch.has_value  <= has_value;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(value, has_value);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    offering = 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_run_count(logic [CFG_W-1:0] count);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_run_count(count);
  endtask

  task automatic load_runs(int unsigned n, int unsigned max_len, int shape);
    logic [KEY_W-1:0] v;
    logic [KEY_W-1:0] step;
    int unsigned      len;
    for (int r = 0; r < MAX_RUNS; r++) begin
      run_data[r].delete();
      if (r < n) begin
        len = $urandom_range(0, max_len);
        case (shape)
          SHAPE_TIES: v = $urandom_range(0, 6);
          SHAPE_TOP:  v = 32'hFFFF_FFF0 + $urandom_range(0, 15);
          default:    v = $urandom >> $urandom_range(0, 31);
        endcase
        for (int k = 0; k < len; k++) begin
          run_data[r] = {run_data[r], v};
          step = (shape == SHAPE_WIDE) ? $urandom_range(0, 100000) : $urandom_range(0, 2);
          if (v > 32'hFFFF_FFFF - step) v = '1;
          else v = v + step;
        end
      end
    end
  endtask

  // Sends transactions until the pass reports done, always serving the run
  // that the block asks for next.
  task automatic drive_pass(int unsigned noise_pct);
    int unsigned      r;
    logic [KEY_W-1:0] v;
    logic             h;
    do begin
      r = sb.merging ? int'(sb.next_refill) : sb.fill_pos;
      if ($urandom_range(0, 99) < noise_pct) begin
        v = $urandom;
        h = 1'($urandom_range(0, 1));
      end else if (run_data[r].size() != 0) begin
        v = run_data[r].pop_front();
        h = 1'b1;
      end else begin
        v = $urandom;
        h = 1'b0;
      end
      put_item(v, h);
    end while (sb.merging || sb.fill_pos != 0);
  endtask

  initial begin
    int unsigned      quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_value, out_ch.out_run, out_ch.done_res);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned      rand_start;
    logic [CFG_W-1:0] count;
    sb = new();
    idle_on       = 1'b0;
    long_hold_req = 1'b0;
    offering      = 1'b0;
    items_sent    = 0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.head_value <= '0;
    in_ch.has_value  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A run count of zero behaves as one run; extreme values go through it,
    // then the same run comes back empty.
    write_run_count(9'd0);
    load_runs(0, 0, SHAPE_TIES);
    run_data[0] = '{32'h0000_0000, 32'hFFFF_FFFF};
    drive_pass(0);
    drive_pass(0);

    // Equal heads must leave in ascending run order.
    write_run_count(9'd3);
    run_data[0] = '{32'd5, 32'd7};
    run_data[1] = '{32'd5};
    run_data[2] = '{32'd5, 32'd5};
    drive_pass(0);
    drive_pass(0);

    // Lowering the run count during the fill phase ends it with the next
    // transaction.
    write_run_count(9'd4);
    run_data[0] = '{32'd9};
    run_data[1] = '{32'd3};
    run_data[2] = '{32'd1};
    put_item(run_data[0].pop_front(), 1'b1);
    put_item(run_data[1].pop_front(), 1'b1);
    write_run_count(9'd2);
    drive_pass(0);

    // Largest register value, clamped to the full heap.
    idle_on = 1'b1;
    write_run_count(9'h1FF);
    load_runs(MAX_RUNS, 1, SHAPE_WIDE);
    drive_pass(4);

    // The output side stops for a long stretch while transactions keep coming.
    write_run_count(9'd8);
    load_runs(8, 6, SHAPE_TIES);
    long_hold_req = 1'b1;
    drive_pass(0);

    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if (items_sent - rand_start > RANDOM_ITEMS - 30) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       count = 9'd0;
          1:       count = 9'd2;
          2:       count = CFG_W'($urandom_range(13, 40));
          default: count = CFG_W'($urandom_range(1, 12));
        endcase
        write_run_count(count);
      end else begin
        drain();
      end
      load_runs(sb.run_limit(), $urandom_range(0, 5), $urandom_range(SHAPE_TIES, SHAPE_TOP));
      drive_pass($urandom_range(0, 1) ? 0 : 8);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
